FILE: sv/somr_pkg.sv
`default_nettype none

package somr_pkg;

    // matrix limits
    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    // field and index widths
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W   = ADDR_W + 1;
    localparam int TOTAL_W = 2 * DIM_W;
    localparam int PROD_W  = ROW_W + DIM_W + 1;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_ROW_COUNT    = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT = CIDX_W'(1);

    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [ADDR_W-1:0]  t_addr;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    // control from the top level to the spiral address generator
    typedef struct packed {
        logic   start;
        logic   step;
        t_dim   rows;
        t_dim   cols;
        t_total total;
    } t_gen_ctl;

    // zero acts as one, anything above the limit acts as the limit
    function automatic t_dim clamp_dim(input t_dim v, input t_dim maxv);
        t_dim res;
        if (v == '0) begin
            res = t_dim'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/spiral_order_matrix_reader_unit.sv
`default_nettype none

// channel   direction  handshake          payload
// element   in         i_valid / o_stall  i_element_value
// spiral    out        o_valid / i_stall  o_spiral_value, o_last_of_run
// config    in         i_cfg_wr_en        i_cfg_index, i_cfg_wr_data
//
// each element is written to the store as it is accepted; the final element of a
// matrix starts a spiral read-out of rows*cols store reads through the single
// read port, one read a cycle while the output queue has room.
// each read passes through r_mem_q and the output queue to o_spiral_value.
// synchronous active-low reset clears counts and state; the store is not cleared.
// i_stall throttles reads through a two-entry output queue; o_stall is high
// while the spiral reads are issued.

module spiral_order_matrix_reader_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [somr_pkg::DATA_W-1:0] i_element_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [somr_pkg::DATA_W-1:0]  o_spiral_value,
    output logic                                o_last_of_run,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [somr_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [somr_pkg::DIM_W-1:0]     i_cfg_wr_data
);
    import somr_pkg::*;

    t_state            r_state, n_state;
    t_dim              r_row_count, r_column_count;
    t_dim              w_rows, w_cols;
    t_total            w_total;
    logic [CNT_W-1:0]  r_load_count, w_load_next;
    logic              w_in_fire, w_load_done, w_issue, w_push, w_pop;
    t_gen_ctl          w_gen_ctl;
    t_addr             w_rd_addr;
    logic              w_gen_last;
    logic [DATA_W-1:0] r_store [STORE_DEPTH];
    logic [DATA_W-1:0] r_mem_q;
    logic              r_rd_valid, r_rd_last;
    logic [DATA_W-1:0] r_q_value [2];
    logic              r_q_last [2];
    logic              r_q_wr_ptr, r_q_rd_ptr;
    logic [1:0]        r_q_count;
    logic [2:0]        w_occ;

    // matrix size in use
    always_comb begin
        w_rows  = clamp_dim(r_row_count, DIM_W'(MAX_ROWS));
        w_cols  = clamp_dim(r_column_count, DIM_W'(MAX_COLS));
        w_total = TOTAL_W'(w_rows * w_cols);
    end

    // load counting
    always_comb begin
        w_in_fire   = i_valid && !o_stall;
        w_load_next = r_load_count + CNT_W'(1);
        w_load_done = (TOTAL_W'(w_load_next) >= w_total);
    end

    // queue occupancy once this cycle settles, reads in flight included
    always_comb begin
        w_pop  = o_valid && !i_stall;
        w_push = r_rd_valid;
        w_occ  = 3'(r_q_count) + 3'(r_rd_valid) - 3'(w_pop);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_fire && w_load_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_issue && w_gen_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_stall         = 1'b1;
        w_issue         = 1'b0;
        w_gen_ctl.start = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_stall         = 1'b0;
                w_gen_ctl.start = w_in_fire && w_load_done;
            end
            ST_EMIT: begin
                w_issue = (w_occ < 3'd2);
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
        w_gen_ctl.step  = w_issue;
        w_gen_ctl.rows  = w_rows;
        w_gen_ctl.cols  = w_cols;
        w_gen_ctl.total = w_total;
    end

    somr_spiral_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gen_ctl),
        .o_addr  (w_rd_addr),
        .o_last  (w_gen_last)
    );

    // control registers and config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_row_count    <= t_dim'(1);
            r_column_count <= t_dim'(1);
            r_load_count   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en && (i_cfg_index == REG_ROW_COUNT)) begin
                r_row_count  <= i_cfg_wr_data;
                r_load_count <= '0;
            end else if (i_cfg_wr_en && (i_cfg_index == REG_COLUMN_COUNT)) begin
                r_column_count <= i_cfg_wr_data;
                r_load_count   <= '0;
            end else if (w_in_fire) begin
                r_load_count <= w_load_done ? '0 : w_load_next;
            end
        end
    end

    // element store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_store[r_load_count[ADDR_W-1:0]] <= i_element_value;
        end
        if (w_issue) begin
            r_mem_q <= r_store[w_rd_addr];
        end
    end

    // read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_issue;
        end
        r_rd_last <= w_issue && w_gen_last;
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr_ptr <= 1'b0;
            r_q_rd_ptr <= 1'b0;
            r_q_count  <= '0;
        end else begin
            if (w_push) begin
                r_q_wr_ptr <= !r_q_wr_ptr;
            end
            if (w_pop) begin
                r_q_rd_ptr <= !r_q_rd_ptr;
            end
            r_q_count <= 2'(3'(r_q_count) + 3'(w_push) - 3'(w_pop));
        end
        if (w_push) begin
            r_q_value[r_q_wr_ptr] <= r_mem_q;
            r_q_last[r_q_wr_ptr]  <= r_rd_last;
        end
    end

    // result transaction
    always_comb begin
        o_valid        = (r_q_count != '0);
        o_spiral_value = r_q_value[r_q_rd_ptr];
        o_last_of_run  = r_q_last[r_q_rd_ptr];
    end

endmodule

`default_nettype wire

FILE: sv/somr_spiral_gen.sv
`default_nettype none

module somr_spiral_gen (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire somr_pkg::t_gen_ctl i_ctl,
    output somr_pkg::t_addr        o_addr,
    output logic                   o_last
);
    import somr_pkg::*;

    logic [ROW_W-1:0] r_row, n_row, r_top, n_top, r_bot, n_bot;
    logic [COL_W-1:0] r_col, n_col, r_left, n_left, r_right, n_right;
    t_dir             r_dir, n_dir;
    t_addr            r_remain, n_remain;
    t_dim             r_cols, n_cols;
    logic [PROD_W-1:0] w_prod;

    // store address of the current coordinate
    always_comb begin
        w_prod = PROD_W'(r_row * r_cols);
        o_addr = ADDR_W'(w_prod + PROD_W'(r_col));
        o_last = (r_remain == '0);
    end

    // walk one coordinate along the spiral, turning at a bound
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_top    = r_top;
        n_bot    = r_bot;
        n_left   = r_left;
        n_right  = r_right;
        n_dir    = r_dir;
        n_remain = r_remain;
        n_cols   = r_cols;
        if (i_ctl.start) begin
            n_row    = '0;
            n_col    = '0;
            n_top    = '0;
            n_bot    = ROW_W'(i_ctl.rows - t_dim'(1));
            n_left   = '0;
            n_right  = COL_W'(i_ctl.cols - t_dim'(1));
            n_dir    = DIR_RIGHT;
            n_remain = ADDR_W'(i_ctl.total - t_total'(1));
            n_cols   = i_ctl.cols;
        end else if (i_ctl.step) begin
            n_remain = r_remain - t_addr'(1);
            case (r_dir)
                DIR_RIGHT: begin
                    if (r_col == r_right) begin
                        n_dir = DIR_DOWN;
                        n_top = r_top + ROW_W'(1);
                        n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
                DIR_DOWN: begin
                    if (r_row == r_bot) begin
                        n_dir   = DIR_LEFT;
                        n_right = r_right - COL_W'(1);
                        n_col   = r_col - COL_W'(1);
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
                DIR_LEFT: begin
                    if (r_col == r_left) begin
                        n_dir = DIR_UP;
                        n_bot = r_bot - ROW_W'(1);
                        n_row = r_row - ROW_W'(1);
                    end else begin
                        n_col = r_col - COL_W'(1);
                    end
                end
                DIR_UP: begin
                    if (r_row == r_top) begin
                        n_dir  = DIR_RIGHT;
                        n_left = r_left + COL_W'(1);
                        n_col  = r_col + COL_W'(1);
                    end else begin
                        n_row = r_row - ROW_W'(1);
                    end
                end
                default: begin
                    n_dir = DIR_RIGHT;
                end
            endcase
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= DIR_RIGHT;
            r_remain <= '0;
        end else begin
            r_dir    <= n_dir;
            r_remain <= n_remain;
        end
        r_row   <= n_row;
        r_col   <= n_col;
        r_top   <= n_top;
        r_bot   <= n_bot;
        r_left  <= n_left;
        r_right <= n_right;
        r_cols  <= n_cols;
    end

endmodule

`default_nettype wire

FILE: sv/somr_checker.sv
`default_nettype none

module somr_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_stall,
    input wire logic                                o_valid,
    input wire logic                                i_stall,
    input wire logic signed [somr_pkg::DATA_W-1:0]  o_spiral_value,
    input wire logic                                o_last_of_run,
    input wire logic                                i_cfg_wr_en
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_spiral_value)
                                  && $stable(o_last_of_run)))
        else $error("stalled result transaction changed");

    // read-out starts only from an accepted element
    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("read-out began without an input transaction");

    // each new result comes from a read issued during read-out
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall, 2))
        else $error("result appeared without a spiral read");

    // register writes must land only while the block is idle; the block itself does not enforce it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> (!o_stall && !o_valid))
        else $error("register write while a read-out was in flight");

endmodule

bind spiral_order_matrix_reader_unit somr_checker u_somr_checker (.*);

`default_nettype wire
